@@ sv/ccc_pkg.sv @@
// Shared types, widths and helpers for the disk collision pipeline.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ccc_pkg;

    localparam int FIELD_W      = 24;
    localparam int RADIUS_W     = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd2304;

    // squared distance width that can still mean contact, and its root
    localparam int D2_W         = 34;
    localparam int ROOT_W       = D2_W / 2;

    // quotient bits of every divider; bounds the largest correction
    localparam int QUO_W        = 26;
    localparam int PUSH_NUM_W   = 35;
    localparam int PUSH_DEN_W   = ROOT_W + 1;
    localparam int DV_NUM_W     = 61;
    localparam int DV_DEN_W     = D2_W;

    // width of a field plus a signed correction before saturation
    localparam int SUM_W        = QUO_W + 2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_pos_x;
        logic signed [FIELD_W-1:0] first_pos_y;
        logic signed [FIELD_W-1:0] first_vel_x;
        logic signed [FIELD_W-1:0] first_vel_y;
        logic signed [FIELD_W-1:0] second_pos_x;
        logic signed [FIELD_W-1:0] second_pos_y;
        logic signed [FIELD_W-1:0] second_vel_x;
        logic signed [FIELD_W-1:0] second_vel_y;
    } pair_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] new_first_pos_x;
        logic signed [FIELD_W-1:0] new_first_pos_y;
        logic signed [FIELD_W-1:0] new_first_vel_x;
        logic signed [FIELD_W-1:0] new_first_vel_y;
        logic signed [FIELD_W-1:0] new_second_pos_x;
        logic signed [FIELD_W-1:0] new_second_pos_y;
        logic signed [FIELD_W-1:0] new_second_vel_x;
        logic signed [FIELD_W-1:0] new_second_vel_y;
        logic                      collided;
    } result_t;

    function automatic logic signed [SUM_W-1:0] widen(input logic signed [FIELD_W-1:0] v);
        return SUM_W'(v);
    endfunction

    // clamp to the signed field range
    function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-FIELD_W:0] top;
        top = v[SUM_W-1:FIELD_W-1];
        if ((&top) || !(|top))
            return v[FIELD_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(FIELD_W-1){1'b0}}};
        else
            return {1'b0, {(FIELD_W-1){1'b1}}};
    endfunction

endpackage

@@ sv/ccc_sqrt_pipe.sv @@
// Pipelined floor square root, one result bit per register stage.
// Depends on ccc_pkg for default widths.
`timescale 1ns / 1ps

module ccc_sqrt_pipe
    import ccc_pkg::*;
#(
    parameter int IN_W = D2_W
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     value,
    output logic [IN_W/2-1:0]   root
);

    localparam int RT_W  = IN_W / 2;
    localparam int REM_W = RT_W + 1;

    logic [REM_W-1:0] rem_reg  [RT_W-1];
    logic [IN_W-1:0]  val_reg  [RT_W-1];
    logic [RT_W-1:0]  root_reg [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_step
        logic [REM_W-1:0] rem_in;
        logic [IN_W-1:0]  val_in;
        logic [RT_W-1:0]  root_in;
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [RT_W-1:0]  root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign val_in  = value;
            assign root_in = '0;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two bits and try root*4+1
        assign shifted   = {rem_in, val_in[IN_W-1:IN_W-2]};
        assign trial     = {1'b0, root_in, 2'b01};
        assign ge        = shifted >= trial;
        assign rem_next  = ge ? REM_W'(shifted - trial) : shifted[REM_W-1:0];
        assign root_next = {root_in[RT_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= root_next;
            end
        end

        if (k < RT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    val_reg[k] <= {val_in[IN_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[RT_W-1];

endmodule

@@ sv/ccc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit Q_W bits. Depends on ccc_pkg for default widths.
`timescale 1ns / 1ps

module ccc_div_pipe
    import ccc_pkg::*;
#(
    parameter int NUM_W = PUSH_NUM_W,
    parameter int DEN_W = PUSH_DEN_W,
    parameter int Q_W   = QUO_W
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg  [Q_W-1];
    logic [DEN_W-1:0] den_reg  [Q_W-1];
    logic [Q_W-1:0]   bits_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   bits_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            // upper numerator bits are below the divisor when the quotient fits
            assign rem_in  = DEN_W'(num >> Q_W);
            assign den_in  = den;
            assign bits_in = num[Q_W-1:0];
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign bits_in = bits_reg[k-1];
        end

        assign trial    = {rem_in, bits_in[Q_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

        // numerator bits leave at the top, quotient bits enter at the bottom
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bits_reg[k] <= {bits_in[Q_W-2:0], ge};
            end
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = bits_reg[Q_W-1];

endmodule

@@ sv/circle_circle_collision.sv @@
// Top level: equal-mass elastic contact of two disks, fully pipelined.
// Depends on ccc_pkg, ccc_sqrt_pipe and ccc_div_pipe.
//
//   channel   signals                        payload
//   req       req_valid / req_ready / req    pair_t, one disk pair
//   rsp       rsp_valid / rsp_ready / rsp    result_t, one resolved pair
//   cfg       cfg_valid / cfg_ready          cfg_data, disk radius
//
// One item enters per cycle while the output buffer is not full; the pipe holds 3 + ROOT_W + 2 + QUO_W + 1
// register stages plus the output buffer, set by the bit-per-stage root and dividers.
// Reset clears all valid bits and loads the radius reset value.
// A stall at rsp holds the whole pipe only once the two-entry output buffer is
// full, so one waiting result does not stop intake.
`timescale 1ns / 1ps

module circle_circle_collision
    import ccc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pair_t               req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output result_t             rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RADIUS_W-1:0] cfg_data
);

    typedef struct packed {
        pair_t                   pair;
        logic signed [17:0]      dx;
        logic signed [17:0]      dy;
        logic [RADIUS_W:0]       twor;
        logic [D2_W-1:0]         d2;
        logic                    hit;
        logic signed [43:0]      dot;
    } sq_side_t;

    typedef struct packed {
        pair_t pair;
        logic  hit;
        logic  neg_px;
        logic  neg_py;
        logic  neg_vx;
        logic  neg_vy;
    } dv_side_t;

    logic [RADIUS_W-1:0] radius_reg;
    logic                adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_valid)
            radius_reg <= cfg_data;
    end

    // ---------------- stage 1: differences
    logic                s1_valid_reg;
    pair_t               s1_pair_reg;
    logic signed [24:0]  s1_dx_reg, s1_dy_reg, s1_wx_reg, s1_wy_reg;
    logic [RADIUS_W:0]   s1_twor_reg;

    assign req_ready = adv;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pair_reg <= req;
            s1_dx_reg   <= 25'(req.first_pos_x) - 25'(req.second_pos_x);
            s1_dy_reg   <= 25'(req.first_pos_y) - 25'(req.second_pos_y);
            s1_wx_reg   <= 25'(req.second_vel_x) - 25'(req.first_vel_x);
            s1_wy_reg   <= 25'(req.second_vel_y) - 25'(req.first_vel_y);
            s1_twor_reg <= {radius_reg, 1'b0};
        end
    end

    // ---------------- stage 2: squares and dot terms
    logic signed [49:0]  sqx_full, sqy_full;
    logic signed [42:0]  px_full, py_full;
    logic signed [17:0]  s1_dx18, s1_dy18;
    logic                s2_valid_reg;
    pair_t               s2_pair_reg;
    logic signed [17:0]  s2_dx_reg, s2_dy_reg;
    logic [48:0]         s2_sqx_reg, s2_sqy_reg;
    logic [2*RADIUS_W+1:0] s2_tr2_reg;
    logic signed [42:0]  s2_px_reg, s2_py_reg;
    logic [RADIUS_W:0]   s2_twor_reg;

    // only a contact matters downstream, and then the offsets fit 18 bits
    assign s1_dx18  = s1_dx_reg[17:0];
    assign s1_dy18  = s1_dy_reg[17:0];
    assign sqx_full = s1_dx_reg * s1_dx_reg;
    assign sqy_full = s1_dy_reg * s1_dy_reg;
    assign px_full  = s1_wx_reg * s1_dx18;
    assign py_full  = s1_wy_reg * s1_dy18;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pair_reg <= s1_pair_reg;
            s2_dx_reg   <= s1_dx18;
            s2_dy_reg   <= s1_dy18;
            s2_sqx_reg  <= sqx_full[48:0];
            s2_sqy_reg  <= sqy_full[48:0];
            s2_tr2_reg  <= s1_twor_reg * s1_twor_reg;
            s2_px_reg   <= px_full;
            s2_py_reg   <= py_full;
            s2_twor_reg <= s1_twor_reg;
        end
    end

    // ---------------- stage 3: distance test
    logic [49:0]         d2_sum;
    logic                s3_valid_reg;
    sq_side_t            s3_side_reg;
    logic [49:0]         s3_d2_reg;

    assign d2_sum = 50'(s2_sqx_reg) + 50'(s2_sqy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_d2_reg        <= d2_sum;
            s3_side_reg.pair <= s2_pair_reg;
            s3_side_reg.dx   <= s2_dx_reg;
            s3_side_reg.dy   <= s2_dy_reg;
            s3_side_reg.twor <= s2_twor_reg;
            s3_side_reg.d2   <= d2_sum[D2_W-1:0];
            s3_side_reg.hit  <= (d2_sum != '0) && (d2_sum < 50'(s2_tr2_reg));
            s3_side_reg.dot  <= 44'(s2_px_reg) + 44'(s2_py_reg);
        end
    end

    // ---------------- square root
    logic [ROOT_W-1:0]   root;
    logic                sq_valid_reg [ROOT_W];
    sq_side_t            sq_side_reg  [ROOT_W];

    ccc_sqrt_pipe #(.IN_W(D2_W)) u_sqrt (
        .clk   (clk),
        .en    (adv),
        .value (s3_side_reg.d2),
        .root  (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= s3_side_reg;
            for (int i = 1; i < ROOT_W; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    // ---------------- stage 4: numerators
    sq_side_t            sq_out;
    logic signed [17:0]  gap;
    logic signed [35:0]  npx_full, npy_full;
    logic signed [61:0]  ndx_full, ndy_full;
    logic                s4_valid_reg;
    pair_t               s4_pair_reg;
    logic                s4_hit_reg;
    logic [ROOT_W-1:0]   s4_root_reg;
    logic [D2_W-1:0]     s4_d2_reg;
    logic signed [35:0]  s4_npx_reg, s4_npy_reg;
    logic signed [61:0]  s4_ndx_reg, s4_ndy_reg;

    assign sq_out   = sq_side_reg[ROOT_W-1];
    assign gap      = $signed({1'b0, sq_out.twor}) - $signed({1'b0, root});
    assign npx_full = gap * sq_out.dx;
    assign npy_full = gap * sq_out.dy;
    assign ndx_full = sq_out.dot * sq_out.dx;
    assign ndy_full = sq_out.dot * sq_out.dy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_pair_reg <= sq_out.pair;
            s4_hit_reg  <= sq_out.hit;
            s4_root_reg <= root;
            s4_d2_reg   <= sq_out.d2;
            s4_npx_reg  <= npx_full;
            s4_npy_reg  <= npy_full;
            s4_ndx_reg  <= ndx_full;
            s4_ndy_reg  <= ndy_full;
        end
    end

    // ---------------- stage 5: magnitudes plus half divisor for rounding
    logic [36:0]           abs_px, abs_py;
    logic [62:0]           abs_vx, abs_vy;
    logic                  s5_valid_reg;
    dv_side_t              s5_side_reg;
    logic [PUSH_NUM_W-1:0] s5_num_px_reg, s5_num_py_reg;
    logic [DV_NUM_W-1:0]   s5_num_vx_reg, s5_num_vy_reg;
    logic [PUSH_DEN_W-1:0] s5_den_push_reg;
    logic [DV_DEN_W-1:0]   s5_den_dv_reg;

    assign abs_px = s4_npx_reg[35] ? -37'(s4_npx_reg) : 37'(s4_npx_reg);
    assign abs_py = s4_npy_reg[35] ? -37'(s4_npy_reg) : 37'(s4_npy_reg);
    assign abs_vx = s4_ndx_reg[61] ? -63'(s4_ndx_reg) : 63'(s4_ndx_reg);
    assign abs_vy = s4_ndy_reg[61] ? -63'(s4_ndy_reg) : 63'(s4_ndy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg.pair   <= s4_pair_reg;
            s5_side_reg.hit    <= s4_hit_reg;
            s5_side_reg.neg_px <= s4_npx_reg[35];
            s5_side_reg.neg_py <= s4_npy_reg[35];
            s5_side_reg.neg_vx <= s4_ndx_reg[61];
            s5_side_reg.neg_vy <= s4_ndy_reg[61];
            s5_num_px_reg      <= PUSH_NUM_W'(abs_px + 37'(s4_root_reg));
            s5_num_py_reg      <= PUSH_NUM_W'(abs_py + 37'(s4_root_reg));
            s5_num_vx_reg      <= DV_NUM_W'(abs_vx + 63'(s4_d2_reg >> 1));
            s5_num_vy_reg      <= DV_NUM_W'(abs_vy + 63'(s4_d2_reg >> 1));
            s5_den_push_reg    <= {s4_root_reg, 1'b0};
            s5_den_dv_reg      <= s4_d2_reg;
        end
    end

    // ---------------- dividers
    logic [QUO_W-1:0]    q_px, q_py, q_vx, q_vy;
    logic                dv_valid_reg [QUO_W];
    dv_side_t            dv_side_reg  [QUO_W];

    ccc_div_pipe #(.NUM_W(PUSH_NUM_W), .DEN_W(PUSH_DEN_W), .Q_W(QUO_W)) u_div_px (
        .clk (clk), .en (adv), .num (s5_num_px_reg), .den (s5_den_push_reg), .quo (q_px)
    );

    ccc_div_pipe #(.NUM_W(PUSH_NUM_W), .DEN_W(PUSH_DEN_W), .Q_W(QUO_W)) u_div_py (
        .clk (clk), .en (adv), .num (s5_num_py_reg), .den (s5_den_push_reg), .quo (q_py)
    );

    ccc_div_pipe #(.NUM_W(DV_NUM_W), .DEN_W(DV_DEN_W), .Q_W(QUO_W)) u_div_vx (
        .clk (clk), .en (adv), .num (s5_num_vx_reg), .den (s5_den_dv_reg), .quo (q_vx)
    );

    ccc_div_pipe #(.NUM_W(DV_NUM_W), .DEN_W(DV_DEN_W), .Q_W(QUO_W)) u_div_vy (
        .clk (clk), .en (adv), .num (s5_num_vy_reg), .den (s5_den_dv_reg), .quo (q_vy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= s5_side_reg;
            for (int i = 1; i < QUO_W; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // ---------------- stage 6: apply and saturate
    dv_side_t            dv_out;
    logic signed [SUM_W-1:0] push_x, push_y, dvel_x, dvel_y;
    result_t             res_next;
    logic                s6_valid_reg;
    result_t             s6_res_reg;

    assign dv_out = dv_side_reg[QUO_W-1];
    assign push_x = dv_out.neg_px ? -$signed(SUM_W'(q_px)) : $signed(SUM_W'(q_px));
    assign push_y = dv_out.neg_py ? -$signed(SUM_W'(q_py)) : $signed(SUM_W'(q_py));
    assign dvel_x = dv_out.neg_vx ? -$signed(SUM_W'(q_vx)) : $signed(SUM_W'(q_vx));
    assign dvel_y = dv_out.neg_vy ? -$signed(SUM_W'(q_vy)) : $signed(SUM_W'(q_vy));

    always_comb
    begin
        res_next.new_first_pos_x  = dv_out.pair.first_pos_x;
        res_next.new_first_pos_y  = dv_out.pair.first_pos_y;
        res_next.new_first_vel_x  = dv_out.pair.first_vel_x;
        res_next.new_first_vel_y  = dv_out.pair.first_vel_y;
        res_next.new_second_pos_x = dv_out.pair.second_pos_x;
        res_next.new_second_pos_y = dv_out.pair.second_pos_y;
        res_next.new_second_vel_x = dv_out.pair.second_vel_x;
        res_next.new_second_vel_y = dv_out.pair.second_vel_y;
        res_next.collided         = dv_out.hit;
        if (dv_out.hit)
        begin
            res_next.new_first_pos_x  = sat_field(widen(dv_out.pair.first_pos_x) + push_x);
            res_next.new_first_pos_y  = sat_field(widen(dv_out.pair.first_pos_y) + push_y);
            res_next.new_first_vel_x  = sat_field(widen(dv_out.pair.first_vel_x) + dvel_x);
            res_next.new_first_vel_y  = sat_field(widen(dv_out.pair.first_vel_y) + dvel_y);
            res_next.new_second_pos_x = sat_field(widen(dv_out.pair.second_pos_x) - push_x);
            res_next.new_second_pos_y = sat_field(widen(dv_out.pair.second_pos_y) - push_y);
            res_next.new_second_vel_x = sat_field(widen(dv_out.pair.second_vel_x) - dvel_x);
            res_next.new_second_vel_y = sat_field(widen(dv_out.pair.second_vel_y) - dvel_y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s6_res_reg <= res_next;
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            for (int i = 0; i < ROOT_W; i++)
                sq_valid_reg[i] <= 1'b0;
            for (int i = 0; i < QUO_W; i++)
                dv_valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= req_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            sq_valid_reg[0] <= s3_valid_reg;
            for (int i = 1; i < ROOT_W; i++)
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            s4_valid_reg    <= sq_valid_reg[ROOT_W-1];
            s5_valid_reg    <= s4_valid_reg;
            dv_valid_reg[0] <= s5_valid_reg;
            for (int i = 1; i < QUO_W; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            s6_valid_reg    <= dv_valid_reg[QUO_W-1];
        end
    end

    // ---------------- two-entry output buffer
    logic [1:0]          cnt_reg, cnt_next;
    result_t             head_reg, head_next;
    result_t             tail_reg, tail_next;
    logic                push, pop;

    assign adv       = (cnt_reg != 2'd2);
    assign push      = adv && s6_valid_reg;
    assign pop       = (cnt_reg != 2'd0) && rsp_ready;
    assign rsp_valid = (cnt_reg != 2'd0);
    assign rsp       = head_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next = s6_res_reg;
                    cnt_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    head_next = s6_res_reg;
                else if (push)
                begin
                    tail_next = s6_res_reg;
                    cnt_next  = 2'd2;
                end
                else if (pop)
                    cnt_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                    cnt_next  = 2'd1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    // ---------------- checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !rsp_ready) |=> (cnt_reg == 2'd2 && $stable(head_reg)))
        else $error("full output buffer changed without a take");

    a_contact_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_side_reg.hit) |-> (s3_d2_reg[49:D2_W] == '0))
        else $error("contact distance exceeds root width");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s6_valid_reg && !adv) |=> (s6_valid_reg && $stable(s6_res_reg)))
        else $error("final stage item lost during stall");

endmodule

@@ sim/ccc_checker.sv @@
// Watches the disk pair and result channels of circle_circle_collision, predicts each
// result from the current radius and compares the whole result at once. Depends on ccc_pkg.
`timescale 1ns / 1ps

module ccc_checker
    import ccc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  pair_t               req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  result_t             rsp,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [RADIUS_W-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending
);

    logic [RADIUS_W-1:0] radius;
    result_t             expected_q[$];

    assign pending = expected_q.size();

    function automatic logic signed [FIELD_W-1:0] clamp(input longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[FIELD_W-1:0];
    endfunction

    // round to nearest, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint floor_root(input longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 18; b >= 0; b--)
        begin
            t = r + (64'sd1 <<< b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic result_t resolve(input pair_t p, input logic [RADIUS_W-1:0] rad);
        result_t o;
        longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        longint dx, dy, d2, twor, root_d, gap, px, py, dot, dvx, dvy;
        p1x = p.first_pos_x;  p1y = p.first_pos_y;
        v1x = p.first_vel_x;  v1y = p.first_vel_y;
        p2x = p.second_pos_x; p2y = p.second_pos_y;
        v2x = p.second_vel_x; v2y = p.second_vel_y;
        dx = p1x - p2x;
        dy = p1y - p2y;
        d2 = dx * dx + dy * dy;
        twor = 2 * longint'(rad);
        o.collided = (d2 != 0) && (d2 < twor * twor);
        if (o.collided)
        begin
            root_d = floor_root(d2);
            gap = twor - root_d;
            px = round_div(gap * dx, 2 * root_d);
            py = round_div(gap * dy, 2 * root_d);
            dot = (v2x - v1x) * dx + (v2y - v1y) * dy;
            dvx = round_div(dot * dx, d2);
            dvy = round_div(dot * dy, d2);
            p1x += px; p1y += py; p2x -= px; p2y -= py;
            v1x += dvx; v1y += dvy; v2x -= dvx; v2y -= dvy;
        end
        o.new_first_pos_x = clamp(p1x);
        o.new_first_pos_y = clamp(p1y);
        o.new_first_vel_x = clamp(v1x);
        o.new_first_vel_y = clamp(v1y);
        o.new_second_pos_x = clamp(p2x);
        o.new_second_pos_y = clamp(p2y);
        o.new_second_vel_x = clamp(v2x);
        o.new_second_vel_y = clamp(v2y);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            radius <= RADIUS_RESET;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radius <= cfg_data;
            if (req_valid && req_ready)
                expected_q.insert(expected_q.size(), resolve(req, radius));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want !== rsp)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h actual %h", want, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_circle_circle_collision.sv @@
// Testbench top for circle_circle_collision: drives disk pairs and radius writes,
// idles both sides at random and gives the verdict. Depends on ccc_pkg, ccc_checker.
`timescale 1ns / 1ps

module tb_circle_circle_collision;
    import ccc_pkg::*;

    localparam int LATENCY    = 50;
    localparam int STALL_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    pair_t               req;
    logic                rsp_valid;
    logic                rsp_ready;
    result_t             rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_data;
    int                  fail_count;
    int                  pending;
    bit                  sink_calm;
    int                  idle_cycles;
    logic [RADIUS_W-1:0] cur_radius;

    circle_circle_collision uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    ccc_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // receiver: random stall bursts unless calm
    initial
    begin
        int n;
        rsp_ready = 0;
        wait (rst_n);
        forever
        begin
            if (!sink_calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 8);
                rsp_ready <= 0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1;
                @(posedge clk);
            end
        end
    end

    // watchdog: cycles with no acceptance on any channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAIL circle_circle_collision");
            $finish;
        end
    end

    function automatic logic signed [FIELD_W-1:0] rnd_field();
        case ($urandom_range(0, 3))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    // a pair placed near contact distance for the current radius, random content
    function automatic pair_t near_pair(input bit wide_vel);
        pair_t p;
        int span;
        span = 2 * cur_radius + 8;
        if (span > 120000)
            span = 120000;
        p.second_pos_x = $urandom_range(0, 1) ? rnd_field() : $signed(24'($urandom_range(0, 65535)));
        p.second_pos_y = $urandom_range(0, 1) ? rnd_field() : $signed(24'($urandom_range(0, 65535)));
        p.first_pos_x = p.second_pos_x + $signed(24'($urandom_range(0, 2 * span) - span));
        p.first_pos_y = p.second_pos_y + $signed(24'($urandom_range(0, 2 * span) - span));
        p.first_vel_x = wide_vel ? rnd_field() : $signed(24'($urandom_range(0, 8191) - 4096));
        p.first_vel_y = wide_vel ? rnd_field() : $signed(24'($urandom_range(0, 8191) - 4096));
        p.second_vel_x = wide_vel ? rnd_field() : $signed(24'($urandom_range(0, 8191) - 4096));
        p.second_vel_y = wide_vel ? rnd_field() : $signed(24'($urandom_range(0, 8191) - 4096));
        return p;
    endfunction

    task automatic send_pair(input pair_t p, input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req <= p;
        req_valid <= 1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drain_idle();
        req_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        drain_idle();
        cfg_data <= r;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        cur_radius = r;
    endtask

    initial
    begin
        pair_t p;
        logic [RADIUS_W-1:0] radii[6];
        rst_n = 0;
        req_valid = 0;
        req = '0;
        cfg_valid = 0;
        cfg_data = '0;
        sink_calm = 0;
        idle_cycles = 0;
        cur_radius = RADIUS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, coincident, touching, overlapping, saturation
        send_pair('0, 0);
        send_pair({8{24'sh7FFFFF}}, 0);
        send_pair({8{24'sh800000}}, 0);
        p = '0; p.first_pos_x = 100; p.first_vel_x = 24'sh7FFFFF;
        p.second_vel_x = 24'sh800000;
        send_pair(p, 0);
        p = '0; p.first_pos_x = 4608;
        send_pair(p, 0);
        p.first_pos_x = 4607;
        send_pair(p, 0);
        p = '0; p.first_pos_x = 24'sh7FFFFF; p.second_pos_x = 24'sh7FFF00;
        p.first_vel_y = 24'sh7FFFFF; p.second_vel_y = 24'sh800000;
        send_pair(p, 0);
        p = '0; p.first_pos_y = 24'sh800000; p.second_pos_y = 24'sh800050;
        p.first_pos_x = 24'sh7FFFFF; p.second_pos_x = 24'sh7FFFF0;
        p.first_vel_x = 24'sh800000; p.second_vel_x = 24'sh7FFFFF;
        p.first_vel_y = 24'sh800000; p.second_vel_y = 24'sh7FFFFF;
        send_pair(p, 0);
        for (int i = 0; i < 8; i++)
            send_pair(near_pair(1), 0);

        write_radius(16'd0);
        p = '0; p.first_pos_x = 1;
        send_pair(p, 0);
        write_radius(16'hFFFF);
        p = '0; p.first_pos_x = 24'sh01FFFD; p.first_vel_x = 24'sh800000;
        p.second_vel_x = 24'sh7FFFFF;
        send_pair(p, 0);
        p = '0; p.first_pos_x = 1; p.first_pos_y = -1;
        send_pair(p, 0);

        // random phases across radii, extremes included
        radii = '{16'd2304, 16'd1, 16'hFFFF, 16'd0, 16'd300, 16'd9000};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_radius(ph == 5 ? 16'($urandom_range(1, 65535)) : radii[ph]);
            for (int i = 0; i < 230; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                    p = near_pair($urandom_range(0, 3) == 0);
                else
                    p = {rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                         rnd_field(), rnd_field(), rnd_field(), rnd_field()};
                send_pair(p, 1);
            end
        end

        // closing stretch with no idling
        drain_idle();
        sink_calm = 1;
        for (int i = 0; i < 150; i++)
            send_pair(near_pair(0), 0);
        req_valid <= 0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("PASS circle_circle_collision");
        else
            $display("FAIL circle_circle_collision");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ccc_pkg.sv
sv/ccc_sqrt_pipe.sv
sv/ccc_div_pipe.sv
sv/circle_circle_collision.sv
sim/ccc_checker.sv
sim/tb_circle_circle_collision.sv
